// ===== src/akg_pkg.sv =====
// shared constants for the auto-increment key generator
// no dependencies; used by akg_rem, autoincrement_key_generator_core and the testbench
package akg_pkg;

    localparam int KEY_W  = 64;
    localparam int STEP_W = 16;
    localparam int CNT_W  = $clog2(KEY_W);

    localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

    // configuration register indexes
    localparam logic REG_START_OFFSET = 1'b0;
    localparam logic REG_STEP_SIZE    = 1'b1;

    // item kinds on the input side
    localparam logic MODE_GENERATE = 1'b0;
    localparam logic MODE_TRACK    = 1'b1;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

endpackage

// ===== src/akg_rem.sv =====
// bit-serial remainder unit: key-wide dividend modulo step-wide divisor
// one dividend bit per cycle, restoring form; depends on akg_pkg
module akg_rem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [akg_pkg::KEY_W-1:0]   dividend,
    input  logic [akg_pkg::STEP_W-1:0]  divisor,
    output logic                        done,
    output logic [akg_pkg::STEP_W-1:0]  rem
);

    localparam logic [akg_pkg::CNT_W-1:0] CNT_LAST = akg_pkg::CNT_W'(akg_pkg::KEY_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [akg_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [akg_pkg::KEY_W-1:0]   shift_reg, shift_next;
    logic [akg_pkg::STEP_W-1:0]  rem_reg, rem_next;
    logic [akg_pkg::STEP_W-1:0]  div_reg, div_next;

    logic [akg_pkg::STEP_W:0]    trial;
    logic [akg_pkg::STEP_W:0]    trial_sub;
    logic                        trial_ge;

    always_comb
    begin
        trial     = {rem_reg, shift_reg[akg_pkg::KEY_W-1]};
        trial_ge  = trial >= {1'b0, div_reg};
        trial_sub = trial - {1'b0, div_reg};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[akg_pkg::KEY_W-2:0], 1'b0};
            // partial remainder stays below the divisor, so the difference fits
            rem_next   = trial_ge ? trial_sub[akg_pkg::STEP_W-1:0] : trial[akg_pkg::STEP_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/autoincrement_key_generator_core.sv =====
// generate: an accepted item passes decode, the divide wait and the exhaustion check to the
//   output register, waiting on the bit-serial remainder unit (one dividend bit per cycle)
// one item at a time; track skips divide and check; last key below offset skips the divide
// the output register frees the datapath; a waiting result stalls only the next item's end
// rst_n (async, active low) clears last key to 0, start offset to 0, step size to 1
// top level of the key generator; depends on akg_pkg and akg_rem
module autoincrement_key_generator_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [akg_pkg::KEY_W-1:0]   cfg_wdata,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [akg_pkg::KEY_W-1:0]   s_tdata,    // tracked_key
    input  logic                        s_tuser,    // mode
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [akg_pkg::KEY_W-1:0]   m_tdata,    // new_key
    output logic                        m_tuser     // status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [akg_pkg::KEY_W-1:0]   offset_reg, offset_next;
    logic [akg_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [akg_pkg::KEY_W-1:0]   last_reg, last_next;
    logic                        mode_reg, mode_next;
    logic [akg_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [akg_pkg::KEY_W-1:0]   cand_reg, cand_next;
    logic                        wrap_reg, wrap_next;
    logic                        status_reg, status_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [akg_pkg::KEY_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    logic [akg_pkg::STEP_W-1:0]  step_eff;
    logic                        rem_start;
    logic                        rem_done;
    logic [akg_pkg::STEP_W-1:0]  rem_val;
    logic [akg_pkg::STEP_W:0]    gap;
    logic [akg_pkg::KEY_W:0]     sum;
    logic                        out_free;

    assign step_eff = (step_reg == '0) ? akg_pkg::STEP_W'(1) : step_reg;
    assign gap      = {1'b0, step_eff} - {1'b0, rem_val};
    assign sum      = {1'b0, last_reg} + (akg_pkg::KEY_W+1)'(gap);
    assign out_free = !m_tvalid_reg || m_tready;

    akg_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (last_reg - offset_reg),
        .divisor  (step_eff),
        .done     (rem_done),
        .rem      (rem_val)
    );

    always_comb
    begin
        state_next    = state_reg;
        offset_next   = offset_reg;
        step_next     = step_reg;
        last_next     = last_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        cand_next     = cand_reg;
        wrap_next     = wrap_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rem_start     = 1'b0;

        if (cfg_we)
        begin
            case (cfg_addr)
                akg_pkg::REG_START_OFFSET: offset_next = cfg_wdata;
                akg_pkg::REG_STEP_SIZE:    step_next   = cfg_wdata[akg_pkg::STEP_W-1:0];
                default:                   offset_next = offset_reg;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    key_next   = s_tdata;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (mode_reg == akg_pkg::MODE_TRACK)
                begin
                    cand_next   = (key_reg > last_reg) ? key_reg : last_reg;
                    status_next = akg_pkg::STATUS_OK;
                    state_next  = S_OUT;
                end
                else if (last_reg < offset_reg)
                begin
                    cand_next  = offset_reg;
                    wrap_next  = 1'b0;
                    state_next = S_CHECK;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_done)
                begin
                    // carry out means the next grid key wrapped below the last key
                    cand_next  = sum[akg_pkg::KEY_W-1:0];
                    wrap_next  = sum[akg_pkg::KEY_W];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (wrap_reg || cand_reg == akg_pkg::KEY_ALL_ONES)
                begin
                    status_next = akg_pkg::STATUS_EXHAUSTED;
                    cand_next   = '0;
                end
                else
                begin
                    status_next = akg_pkg::STATUS_OK;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = cand_reg;
                    m_tuser_next  = status_reg;
                    if (status_reg == akg_pkg::STATUS_OK)
                    begin
                        last_next = cand_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            offset_reg   <= '0;
            step_reg     <= akg_pkg::STEP_W'(1);
            last_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            offset_reg   <= offset_next;
            step_reg     <= step_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        cand_reg    <= cand_next;
        wrap_reg    <= wrap_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // an exhausted result never carries a key
    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == akg_pkg::STATUS_EXHAUSTED) |-> m_tdata == '0)
        else $error("exhausted item carries a nonzero key");

    // the last assigned key never moves down
    a_last_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> last_reg >= $past(last_reg))
        else $error("last key decreased");

    // a good result is the new last key
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free && status_reg == akg_pkg::STATUS_OK)
        |=> (last_reg == m_tdata && m_tvalid))
        else $error("last key does not match delivered key");

    // accepted item always moves to decode
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg == S_START)
        else $error("accepted item not decoded");

    // remainder unit only finishes while waiting on it
    a_rem_done_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == S_DIV)
        else $error("remainder done outside divide wait");

endmodule

// ===== tb/autoincrement_key_generator_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for autoincrement_key_generator_core: generate and track items
// with random bursts and output stalls, checked against a local key predictor; needs akg_pkg
module autoincrement_key_generator_core_tb;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [akg_pkg::KEY_W-1:0] key;
        logic                      status;
    } key_result_t;

    // predicts the key sequence and holds the results still owed by the block
    class key_sequence_checker;
        logic [akg_pkg::KEY_W-1:0]  grid_origin;
        logic [akg_pkg::STEP_W-1:0] grid_step;
        logic [akg_pkg::KEY_W-1:0]  last_key;
        key_result_t                expected_results[$];
        int                         errors;

        function new();
            grid_origin = '0;
            grid_step   = akg_pkg::STEP_W'(1);
            last_key    = '0;
            errors      = 0;
        endfunction

        function void write_register(logic idx, logic [akg_pkg::KEY_W-1:0] value);
            if (idx == akg_pkg::REG_START_OFFSET)
                grid_origin = value;
            else
                grid_step = value[akg_pkg::STEP_W-1:0];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic mode, logic [akg_pkg::KEY_W-1:0] user_key);
            key_result_t               r;
            logic [akg_pkg::KEY_W-1:0] stride;
            logic [akg_pkg::KEY_W-1:0] rem;
            logic [akg_pkg::KEY_W-1:0] cand;
            if (mode == akg_pkg::MODE_TRACK)
            begin
                if (user_key > last_key)
                    last_key = user_key;
                r = '{last_key, akg_pkg::STATUS_OK};
            end
            else
            begin
                // a zero step behaves as a step of one
                stride = akg_pkg::KEY_W'((grid_step == '0) ? akg_pkg::STEP_W'(1) : grid_step);
                if (last_key < grid_origin)
                    cand = grid_origin;
                else
                begin
                    rem  = (last_key - grid_origin) % stride;
                    cand = last_key + (stride - rem);
                end
                if (cand == akg_pkg::KEY_ALL_ONES || cand < last_key)
                    r = '{'0, akg_pkg::STATUS_EXHAUSTED};
                else
                begin
                    last_key = cand;
                    r = '{cand, akg_pkg::STATUS_OK};
                end
            end
            expected_results.push_back(r);
        endfunction

        task report(string what, logic [akg_pkg::KEY_W-1:0] got,
                    logic [akg_pkg::KEY_W-1:0] want);
            $display("mismatch in %s: got %h, want %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [akg_pkg::KEY_W-1:0] key, logic status);
            key_result_t want;
            if (expected_results.size() == 0)
            begin
                report("item with nothing pending", key, '0);
                return;
            end
            want = expected_results.pop_front();
            if (key !== want.key)
                report("new_key", key, want.key);
            if (status !== want.status)
                report("status", akg_pkg::KEY_W'(status), akg_pkg::KEY_W'(want.status));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic                      cfg_addr;
    logic [akg_pkg::KEY_W-1:0] cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [akg_pkg::KEY_W-1:0] s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [akg_pkg::KEY_W-1:0] m_tdata;
    logic                      m_tuser;

    int cycle_count;

    key_sequence_checker key_sb = new();

    autoincrement_key_generator_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = akg_pkg::REG_START_OFFSET;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = akg_pkg::MODE_GENERATE;
        m_tready  = 1'b0;
        cycle_count = 0;
    end

    always #10 clk = ~clk;

    // receiver stall pattern cycles through four styles; also the run limit
    always @(posedge clk)
    begin
        case ((cycle_count / 300) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle_count % 5 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            key_sb.check_result(m_tdata, m_tuser);
    end

    function automatic logic [akg_pkg::KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // mostly keys that keep the last key low, so the grid stays reachable
    function automatic logic [akg_pkg::KEY_W-1:0] pick_tracked_key(bit near_top);
        logic [akg_pkg::KEY_W-1:0] last;
        last = key_sb.last_key;
        case ($urandom_range(0, near_top ? 5 : 4))
            0: return '0;
            1: return last >> 1;
            2: return last;
            3, 4: return last + akg_pkg::KEY_W'($urandom_range(1, 100000));
            default: return rand_key();
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [akg_pkg::KEY_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        key_sb.note_request(mode, key);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (key_sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [akg_pkg::KEY_W-1:0] origin,
                                input logic [akg_pkg::STEP_W-1:0] stride);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= akg_pkg::REG_START_OFFSET;
        cfg_wdata <= origin;
        @(posedge clk);
        key_sb.write_register(akg_pkg::REG_START_OFFSET, origin);
        cfg_addr  <= akg_pkg::REG_STEP_SIZE;
        cfg_wdata <= {{(akg_pkg::KEY_W-akg_pkg::STEP_W){1'b0}}, stride};
        @(posedge clk);
        key_sb.write_register(akg_pkg::REG_STEP_SIZE,
                              {{(akg_pkg::KEY_W-akg_pkg::STEP_W){1'b0}}, stride});
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items, input bit near_top);
        int                        sent;
        int                        burst;
        int                        gap;
        logic                      mode;
        logic [akg_pkg::KEY_W-1:0] key;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n_items; i++)
            begin
                mode = ($urandom_range(0, 3) == 0) ? akg_pkg::MODE_TRACK : akg_pkg::MODE_GENERATE;
                // generate items carry random data that the block must ignore
                key = (mode == akg_pkg::MODE_TRACK) ? pick_tracked_key(near_top) : rand_key();
                send_item(mode, key);
                sent++;
            end
            case ($urandom_range(0, 9))
                0, 1: gap = 0;
                9:
                begin
                    drain();
                    gap = 0;
                end
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [akg_pkg::KEY_W-1:0]  origin;
        logic [akg_pkg::STEP_W-1:0] stride;
        logic [akg_pkg::KEY_W-1:0]  last;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, zero and equal tracked keys
        send_item(akg_pkg::MODE_GENERATE, '0);
        send_item(akg_pkg::MODE_TRACK, '0);
        send_item(akg_pkg::MODE_TRACK, 64'd1);
        send_item(akg_pkg::MODE_TRACK, 64'd1000);
        send_item(akg_pkg::MODE_GENERATE, akg_pkg::KEY_ALL_ONES);
        send_item(akg_pkg::MODE_GENERATE, '0);
        // step of zero acts as one
        write_config('0, '0);
        send_item(akg_pkg::MODE_GENERATE, '0);
        // offset of all ones: every generate is exhausted
        write_config(akg_pkg::KEY_ALL_ONES, 16'd1);
        send_item(akg_pkg::MODE_GENERATE, '0);
        send_item(akg_pkg::MODE_TRACK, 64'd5);
        send_item(akg_pkg::MODE_GENERATE, '0);
        // largest step, grid off the current key
        write_config(64'd7, 16'hFFFF);
        send_item(akg_pkg::MODE_GENERATE, '0);
        send_item(akg_pkg::MODE_GENERATE, '0);
        // offset above the last key
        write_config(64'd1 << 40, 16'd3);
        send_item(akg_pkg::MODE_GENERATE, '0);
        send_item(akg_pkg::MODE_GENERATE, '0);

        for (int p = 0; p < 8; p++)
        begin
            drain();
            last = key_sb.last_key;
            case (p)
                0:
                begin
                    origin = '0;
                    stride = 16'd1;
                end
                1:
                begin
                    origin = last + akg_pkg::KEY_W'($urandom_range(1, 5000));
                    stride = 16'hFFFF;
                end
                2:
                begin
                    origin = (last == 0) ? '0 : rand_key() % last;
                    stride = akg_pkg::STEP_W'($urandom_range(1, 16));
                end
                default:
                begin
                    if ($urandom_range(0, 1) && last != 0)
                        origin = rand_key() % last;
                    else
                        origin = last + akg_pkg::KEY_W'($urandom_range(1, 1 << 20));
                    stride = akg_pkg::STEP_W'($urandom_range(1, 65535));
                end
            endcase
            write_config(origin, stride);
            run_random_phase(58, 1'b0);
        end

        // near the top of the key space, where exhaustion shows up
        write_config(rand_key(), akg_pkg::STEP_W'($urandom_range(1, 65535)));
        send_item(akg_pkg::MODE_TRACK,
                  akg_pkg::KEY_ALL_ONES - akg_pkg::KEY_W'($urandom_range(0, 200000)));
        run_random_phase(40, 1'b1);

        // candidate equal to all ones, then wrap past the top
        write_config('0, 16'd1);
        send_item(akg_pkg::MODE_TRACK, akg_pkg::KEY_ALL_ONES - 64'd2);
        send_item(akg_pkg::MODE_GENERATE, '0);
        send_item(akg_pkg::MODE_GENERATE, '0);
        write_config(64'd5, 16'hFFFF);
        send_item(akg_pkg::MODE_GENERATE, '0);
        send_item(akg_pkg::MODE_TRACK, akg_pkg::KEY_ALL_ONES);
        send_item(akg_pkg::MODE_GENERATE, akg_pkg::KEY_ALL_ONES);

        drain();
        repeat (100) @(posedge clk);
        if (key_sb.errors == 0 && key_sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/akg_pkg.sv
src/akg_rem.sv
src/autoincrement_key_generator_core.sv
tb/autoincrement_key_generator_core_tb.sv
